// ----- rtl/efra_pkg.sv -----
package efra_pkg;

    localparam int MAX_ROOMS  = 128;
    localparam int TIME_BITS  = 48;
    localparam int START_BITS = 32;
    localparam int COUNT_BITS = 16;
    localparam int CFG_W      = 8;
    localparam int ROOM_W     = (MAX_ROOMS > 1) ? $clog2(MAX_ROOMS) : 1;
    localparam int NUM_W      = $clog2(MAX_ROOMS + 1);
    localparam int WORD_W     = COUNT_BITS + TIME_BITS;

    localparam logic [CFG_W-1:0] ROOM_COUNT_RESET = CFG_W'(128);

    typedef logic [TIME_BITS-1:0]  time_t;
    typedef logic [START_BITS-1:0] start_t;
    typedef logic [COUNT_BITS-1:0] count_t;
    typedef logic [ROOM_W-1:0]     room_t;
    typedef logic [NUM_W-1:0]      num_t;

    // one room entry as it streams out of the room memory
    typedef struct packed {
        logic   valid;
        logic   first;
        room_t  room;
        time_t  free_at;
        count_t count;
    } scan_entry_t;

    // running answer of the room scan
    typedef struct packed {
        logic   found;
        room_t  found_room;
        count_t found_count;
        room_t  early_room;
        time_t  early_free;
        count_t early_count;
    } scan_result_t;

    // zero means one room, anything above capacity means all rooms
    function automatic num_t rooms_in_use(input logic [CFG_W-1:0] cfg);
        num_t n;
        if (cfg == '0)
        begin
            n = NUM_W'(1);
        end
        else if (int'(cfg) > MAX_ROOMS)
        begin
            n = NUM_W'(MAX_ROOMS);
        end
        else
        begin
            n = NUM_W'(cfg);
        end
        return n;
    endfunction

endpackage

// ----- rtl/efra_ifs.sv -----
interface efra_req_if;
    import efra_pkg::*;
    logic   valid;
    logic   ready;
    start_t start_time;
    start_t end_time;
    logic   last_meeting;

    modport source (output valid, start_time, end_time, last_meeting, input ready);
    modport sink   (input valid, start_time, end_time, last_meeting, output ready);
endinterface

interface efra_rsp_if;
    import efra_pkg::*;
    logic  valid;
    logic  ready;
    room_t room_index;
    logic  delayed;
    time_t finish_time;
    room_t busiest_room;
    logic  batch_done;

    modport source (output valid, room_index, delayed, finish_time, busiest_room,
                    batch_done, input ready);
    modport sink   (input valid, room_index, delayed, finish_time, busiest_room,
                    batch_done, output ready);
endinterface

interface efra_cfg_if;
    import efra_pkg::*;
    logic             valid;
    logic             ready;
    logic [CFG_W-1:0] room_count;

    modport source (output valid, room_count, input ready);
    modport sink   (input valid, room_count, output ready);
endinterface

// ----- rtl/earliest_free_room_allocator.sv -----
// Channel  | Dir | Handshake    | Payload
// ---------+-----+--------------+-------------------------------------------------
// req      | in  | valid/ready  | start_time, end_time, last_meeting
// rsp      | out | valid/ready  | room_index, delayed, finish_time, busiest_room,
//          |     |              | batch_done
// cfg      | in  | valid/ready  | room_count (always ready)
//
// Per request: the request is taken, the room memory is read one room per
// cycle through its single read port for the rooms in use, the read pipe
// drains, then the chosen room is written back.
// Reset clears all rooms at once through per-room valid bits; a batch end
// does the same, so no clearing pass is needed.
// A new request is taken while a response still sits in the output register;
// only the write-back step waits if that register is still full.
module earliest_free_room_allocator (
    input  logic       clk,
    input  logic       rst_n,
    efra_req_if.sink   req,
    efra_rsp_if.source rsp,
    efra_cfg_if.sink   cfg
);
    import efra_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_DRAIN  = 4'b0100,
        S_UPDATE = 4'b1000
    } state_t;

    state_t                 state_reg, state_next;
    logic [CFG_W-1:0]       room_count_reg;
    room_t                  addr_reg, last_addr_reg;
    start_t                 start_reg, end_reg;
    logic                   last_reg;
    logic                   pipe_valid_reg;
    room_t                  pipe_room_reg;
    logic                   ent_valid_reg;
    logic [MAX_ROOMS-1:0]   valid_reg;
    count_t                 best_count_reg, best_count_next;
    room_t                  best_room_reg, best_room_next;

    logic                   out_valid_reg;
    room_t                  out_room_reg;
    logic                   out_delayed_reg;
    time_t                  out_finish_reg;
    room_t                  out_busiest_reg;
    logic                   out_done_reg;

    logic                   req_take;
    logic                   out_free;
    logic                   commit;
    num_t                   rooms_n;
    logic [WORD_W-1:0]      ram_q;
    logic [WORD_W-1:0]      ram_wdata;
    scan_entry_t            entry;
    scan_result_t           scan_res;

    // write-back arithmetic
    room_t                  sel_room;
    count_t                 sel_count;
    count_t                 new_count;
    start_t                 duration;
    logic [TIME_BITS:0]     delay_sum;
    time_t                  finish;
    logic                   better;

    assign req.ready = (state_reg == S_IDLE);
    assign req_take  = req.valid && req.ready;
    assign cfg.ready = 1'b1;
    assign rooms_n   = rooms_in_use(room_count_reg);

    assign out_free  = !out_valid_reg || rsp.ready;
    assign commit    = (state_reg == S_UPDATE) && out_free;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_take)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (addr_reg == last_addr_reg)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_UPDATE;
            end
            S_UPDATE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // room memory: {use count, free-at time}
    efra_room_ram #(
        .DEPTH (MAX_ROOMS),
        .WIDTH (WORD_W)
    ) u_ram (
        .clk   (clk),
        .we    (commit),
        .waddr (sel_room),
        .wdata (ram_wdata),
        .re    (state_reg == S_SCAN),
        .raddr (addr_reg),
        .rdata (ram_q)
    );

    // rooms not written since reset or the last batch end read as zero
    always_comb
    begin
        entry.valid   = pipe_valid_reg;
        entry.first   = (pipe_room_reg == '0);
        entry.room    = pipe_room_reg;
        entry.free_at = ent_valid_reg ? ram_q[TIME_BITS-1:0] : '0;
        entry.count   = ent_valid_reg ? ram_q[WORD_W-1:TIME_BITS] : '0;
    end

    efra_scan u_scan (
        .clk        (clk),
        .entry      (entry),
        .start_time (start_reg),
        .result     (scan_res)
    );

    // pick the room and work out its new free-at time and count
    always_comb
    begin
        duration  = (end_reg > start_reg) ? (end_reg - start_reg) : '0;
        delay_sum = {1'b0, scan_res.early_free} + (TIME_BITS + 1)'(duration);
        if (scan_res.found)
        begin
            sel_room  = scan_res.found_room;
            sel_count = scan_res.found_count;
            finish    = TIME_BITS'(end_reg);
        end
        else
        begin
            sel_room  = scan_res.early_room;
            sel_count = scan_res.early_count;
            finish    = delay_sum[TIME_BITS] ? '1 : delay_sum[TIME_BITS-1:0];
        end
        new_count = (sel_count == '1) ? sel_count : sel_count + 1'b1;
        ram_wdata = {new_count, finish};
        better    = (new_count > best_count_reg) ||
                    ((new_count == best_count_reg) && (sel_room < best_room_reg));
        best_count_next = better ? new_count : best_count_reg;
        best_room_next  = better ? sel_room  : best_room_reg;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            room_count_reg <= ROOM_COUNT_RESET;
            addr_reg       <= '0;
            pipe_valid_reg <= 1'b0;
            valid_reg      <= '0;
            best_count_reg <= '0;
            best_room_reg  <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            pipe_valid_reg <= (state_reg == S_SCAN);
            if (cfg.valid && cfg.ready)
            begin
                room_count_reg <= cfg.room_count;
            end
            if (req_take)
            begin
                addr_reg <= '0;
            end
            else if (state_reg == S_SCAN)
            begin
                addr_reg <= addr_reg + 1'b1;
            end
            if (commit)
            begin
                out_valid_reg <= 1'b1;
                if (last_reg)
                begin
                    // batch end: every room back to its reset value
                    valid_reg      <= '0;
                    best_count_reg <= '0;
                    best_room_reg  <= '0;
                end
                else
                begin
                    valid_reg[sel_room] <= 1'b1;
                    best_count_reg      <= best_count_next;
                    best_room_reg       <= best_room_next;
                end
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (req_take)
        begin
            start_reg     <= req.start_time;
            end_reg       <= req.end_time;
            last_reg      <= req.last_meeting;
            last_addr_reg <= ROOM_W'(rooms_n - 1'b1);
        end
        pipe_room_reg <= addr_reg;
        ent_valid_reg <= valid_reg[addr_reg];
        if (commit)
        begin
            out_room_reg    <= sel_room;
            out_delayed_reg <= !scan_res.found;
            out_finish_reg  <= finish;
            out_busiest_reg <= best_room_next;
            out_done_reg    <= last_reg;
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.room_index   = out_room_reg;
    assign rsp.delayed      = out_delayed_reg;
    assign rsp.finish_time  = out_finish_reg;
    assign rsp.busiest_room = out_busiest_reg;
    assign rsp.batch_done   = out_done_reg;

endmodule

// ----- rtl/efra_room_ram.sv -----
module efra_room_ram #(
    parameter int DEPTH = 128,
    parameter int WIDTH = 64
) (
    input  logic                                          clk,
    input  logic                                          we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  waddr,
    input  logic [WIDTH-1:0]                              wdata,
    input  logic                                          re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  raddr,
    output logic [WIDTH-1:0]                              rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- rtl/efra_scan.sv -----
module efra_scan (
    input  logic                  clk,
    input  efra_pkg::scan_entry_t entry,
    input  efra_pkg::start_t      start_time,
    output efra_pkg::scan_result_t result
);
    import efra_pkg::*;

    scan_result_t res_reg;
    scan_result_t res_next;
    logic         cur_found;
    logic         is_free;

    always_comb
    begin
        res_next  = res_reg;
        cur_found = entry.first ? 1'b0 : res_reg.found;
        is_free   = entry.free_at <= TIME_BITS'(start_time);
        res_next.found = cur_found | is_free;
        if (!cur_found && is_free)
        begin
            res_next.found_room  = entry.room;
            res_next.found_count = entry.count;
        end
        // strict less keeps the lowest index on ties
        if (entry.first || (entry.free_at < res_reg.early_free))
        begin
            res_next.early_room  = entry.room;
            res_next.early_free  = entry.free_at;
            res_next.early_count = entry.count;
        end
    end

    always_ff @(posedge clk)
    begin
        if (entry.valid)
        begin
            res_reg <= res_next;
        end
    end

    assign result = res_reg;

endmodule

// ----- rtl/efra_checker.sv -----
module efra_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             req_valid,
    input logic             req_ready,
    input efra_pkg::start_t req_start,
    input efra_pkg::start_t req_end,
    input logic             req_last,
    input logic             rsp_valid,
    input logic             rsp_ready,
    input efra_pkg::room_t  rsp_room,
    input logic             rsp_delayed,
    input efra_pkg::time_t  rsp_finish,
    input efra_pkg::room_t  rsp_busiest,
    input logic             rsp_done
);
    import efra_pkg::*;

    start_t start_reg;
    start_t end_reg;
    logic   last_reg;
    logic   prev_valid_reg;
    logic   prev_ready_reg;
    logic   new_rsp;

    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
        begin
            start_reg <= req_start;
            end_reg   <= req_end;
            last_reg  <= req_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_valid_reg <= 1'b0;
            prev_ready_reg <= 1'b0;
        end
        else
        begin
            prev_valid_reg <= rsp_valid;
            prev_ready_reg <= rsp_ready;
        end
    end

    assign new_rsp = rsp_valid && (!prev_valid_reg || prev_ready_reg);

    // one request in flight: taking one closes the door for the next cycle
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> !req_ready)
        else $error("request taken while another is in flight");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_room) &&
        $stable(rsp_finish) && $stable(rsp_busiest) && $stable(rsp_delayed)))
        else $error("stalled response changed");

    a_free_finish: assert property (@(posedge clk) disable iff (!rst_n)
        (new_rsp && !rsp_delayed) |-> (rsp_finish == TIME_BITS'(end_reg)))
        else $error("free room finish differs from meeting end");

    a_delay_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        (new_rsp && rsp_delayed) |-> (rsp_finish > TIME_BITS'(start_reg)))
        else $error("postponed meeting finishes before its start");

    a_done_flag: assert property (@(posedge clk) disable iff (!rst_n)
        new_rsp |-> (rsp_done == last_reg))
        else $error("batch_done does not match the request");

endmodule

bind earliest_free_room_allocator efra_checker u_efra_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (req.valid),
    .req_ready   (req.ready),
    .req_start   (req.start_time),
    .req_end     (req.end_time),
    .req_last    (req.last_meeting),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .rsp_room    (rsp.room_index),
    .rsp_delayed (rsp.delayed),
    .rsp_finish  (rsp.finish_time),
    .rsp_busiest (rsp.busiest_room),
    .rsp_done    (rsp.batch_done)
);

// ----- bench/efra_booking_checker.sv -----
`timescale 1ns / 100ps

module efra_booking_checker (
    input  logic clk,
    input  logic rst_n,
    efra_req_if  req,
    efra_rsp_if  rsp,
    efra_cfg_if  cfg,
    output int   mismatch_count,
    output int   open_bookings
);
    import efra_pkg::*;

    typedef struct packed {
        room_t room;
        logic  delayed;
        time_t finish;
        room_t busiest;
        logic  done;
    } booking_t;

    time_t            free_at [MAX_ROOMS];
    count_t           uses [MAX_ROOMS];
    count_t           top_uses;
    room_t            top_room;
    logic [CFG_W-1:0] room_limit;

    booking_t bookings [$];
    int       errors;

    function automatic void clear_rooms();
        foreach (free_at[r])
        begin
            free_at[r] = '0;
            uses[r]    = '0;
        end
        top_uses = '0;
        top_room = '0;
    endfunction

    // lowest free room, else the earliest to free up (lowest index on ties)
    function automatic booking_t book_meeting(input start_t s, input start_t e,
                                              input logic last);
        booking_t             b;
        int                   n;
        int                   pick;
        int                   early;
        logic                 hit;
        start_t               dur;
        logic [TIME_BITS:0]   sum;
        time_t                fin;
        n     = (room_limit == '0) ? 1 :
                ((int'(room_limit) > MAX_ROOMS) ? MAX_ROOMS : int'(room_limit));
        pick  = 0;
        early = 0;
        hit   = 1'b0;
        for (int r = 0; r < n; r++)
        begin
            if (!hit && free_at[r] <= time_t'(s))
            begin
                pick = r;
                hit  = 1'b1;
            end
            if (free_at[r] < free_at[early])
            begin
                early = r;
            end
        end
        if (hit)
        begin
            fin = time_t'(e);
        end
        else
        begin
            pick = early;
            dur  = (e > s) ? e - s : '0;
            sum  = {1'b0, free_at[pick]} + (TIME_BITS+1)'(dur);
            fin  = sum[TIME_BITS] ? '1 : sum[TIME_BITS-1:0];
        end
        free_at[pick] = fin;
        if (uses[pick] != '1)
        begin
            uses[pick] = uses[pick] + 1'b1;
        end
        if (uses[pick] > top_uses || (uses[pick] == top_uses && room_t'(pick) < top_room))
        begin
            top_uses = uses[pick];
            top_room = room_t'(pick);
        end
        b.room    = room_t'(pick);
        b.delayed = !hit;
        b.finish  = fin;
        b.busiest = top_room;
        b.done    = last;
        if (last)
        begin
            clear_rooms();
        end
        return b;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        booking_t want;
        booking_t got;
        if (!rst_n)
        begin
            clear_rooms();
            room_limit = ROOM_COUNT_RESET;
            bookings.delete();
            errors = 0;
            mismatch_count <= 0;
            open_bookings  <= 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                room_limit = cfg.room_count;
            end
            if (rsp.valid && rsp.ready)
            begin
                got.room    = rsp.room_index;
                got.delayed = rsp.delayed;
                got.finish  = rsp.finish_time;
                got.busiest = rsp.busiest_room;
                got.done    = rsp.batch_done;
                if (bookings.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                    begin
                        $display("chk: unexpected rsp room %0d dly %0b fin %0h",
                                 got.room, got.delayed, got.finish);
                    end
                end
                else
                begin
                    want = bookings.pop_front();
                    if (want.room != got.room || want.delayed != got.delayed ||
                        want.finish != got.finish || want.busiest != got.busiest ||
                        want.done != got.done)
                    begin
                        errors++;
                        if (errors <= 10)
                        begin
                            $display("chk: exp room %0d dly %0b fin %0h busy %0d done %0b",
                                     want.room, want.delayed, want.finish, want.busiest,
                                     want.done);
                            $display("chk: got room %0d dly %0b fin %0h busy %0d done %0b",
                                     got.room, got.delayed, got.finish, got.busiest,
                                     got.done);
                        end
                    end
                end
            end
            if (req.valid && req.ready)
            begin
                bookings.push_back(book_meeting(req.start_time, req.end_time,
                                                req.last_meeting));
            end
            mismatch_count <= errors;
            open_bookings  <= bookings.size();
        end
    end

endmodule

// ----- bench/earliest_free_room_allocator_tb.sv -----
`timescale 1ns / 100ps

module earliest_free_room_allocator_tb;
    import efra_pkg::*;

    logic clk;
    logic rst_n;
    int   idle_pct;
    int   mismatch_count;
    int   open_bookings;

    efra_req_if req_ch ();
    efra_rsp_if rsp_ch ();
    efra_cfg_if cfg_ch ();

    earliest_free_room_allocator dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    // watches all three channels, predicts every response and compares
    efra_booking_checker chk (
        .clk            (clk),
        .rst_n          (rst_n),
        .req            (req_ch),
        .rsp            (rsp_ch),
        .cfg            (cfg_ch),
        .mismatch_count (mismatch_count),
        .open_bookings  (open_bookings)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // hard stop in case the block hangs
    initial
    begin
        #(20_000_000);
        $display("tb: failure");
        $finish;
    end

    // response side: random back-pressure, one decision per cycle
    always @(posedge clk)
    begin
        rsp_ch.ready <= ($urandom_range(99) >= idle_pct);
    end

    // Offer one request after a random number of idle cycles. Valid stays
    // high after the handshake so back-to-back requests never toggle it
    // within one step; idle cycles and drain waits lower it.
    task automatic send_meeting(input start_t s, input start_t e, input logic last);
        while ($urandom_range(99) < idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.start_time   <= s;
        req_ch.end_time     <= e;
        req_ch.last_meeting <= last;
        @(posedge clk);
        while (!req_ch.ready)
        begin
            @(posedge clk);
        end
    endtask

    // stop sending and hold off until every predicted response is back;
    // the first edge lets the checker see the final request
    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (open_bookings != 0)
        begin
            @(posedge clk);
        end
    endtask

    // only called while the block is idle
    task automatic set_room_count(input logic [CFG_W-1:0] v);
        cfg_ch.valid      <= 1'b1;
        cfg_ch.room_count <= v;
        @(posedge clk);
        while (!cfg_ch.ready)
        begin
            @(posedge clk);
        end
        cfg_ch.valid <= 1'b0;
    endtask

    initial
    begin
        int               sent;
        int               len;
        int               sel;
        int               gap_max;
        int               dur_max;
        logic [CFG_W-1:0] rc;
        start_t           s;
        start_t           e;
        start_t           cursor;
        logic             last;
        logic             batch_open;
        logic [32:0]      acc;

        // every input known from time zero
        rst_n               = 1'b0;
        idle_pct            = 17;
        req_ch.valid        = 1'b0;
        req_ch.start_time   = '0;
        req_ch.end_time     = '0;
        req_ch.last_meeting = 1'b0;
        rsp_ch.ready        = 1'b0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.room_count   = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // --- directed: four rooms ---
        set_room_count(CFG_W'(4));
        send_meeting(32'd0, 32'd10, 1'b0);
        send_meeting(32'd0, 32'hFFFF_FFFF, 1'b0);
        send_meeting(32'd5, 32'd5, 1'b0);               // end equals start
        send_meeting(32'd5, 32'd3, 1'b0);               // end before start, free room
        send_meeting(32'd5, 32'd7, 1'b0);
        send_meeting(32'd6, 32'd20, 1'b0);
        send_meeting(32'd6, 32'd9, 1'b0);               // all busy: delayed
        send_meeting(32'd6, 32'd6, 1'b0);               // delayed, zero duration, tie
        send_meeting(32'd2, 32'd4, 1'b0);               // start goes backward
        send_meeting(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        send_meeting(32'd100, 32'd200, 1'b1);
        wait_drained();

        // zero room count acts as one room
        set_room_count(CFG_W'(0));
        send_meeting(32'd0, 32'd1, 1'b0);
        send_meeting(32'd0, 32'd1, 1'b0);
        send_meeting(32'd1, 32'd0, 1'b1);
        wait_drained();

        // shrink the room count in the middle of a batch
        set_room_count(CFG_W'(3));
        send_meeting(32'd0, 32'd50, 1'b0);
        send_meeting(32'd0, 32'd50, 1'b0);
        send_meeting(32'd0, 32'd50, 1'b0);
        send_meeting(32'd0, 32'd60, 1'b0);
        wait_drained();
        set_room_count(CFG_W'(1));
        send_meeting(32'd10, 32'd20, 1'b0);
        wait_drained();
        // above capacity saturates to all rooms
        set_room_count(CFG_W'(255));
        send_meeting(32'd10, 32'd20, 1'b0);
        send_meeting(32'd20, 32'd30, 1'b1);
        wait_drained();

        // --- fill every room, then spill into delays ---
        set_room_count(CFG_W'(MAX_ROOMS));
        for (int i = 0; i < MAX_ROOMS + 2; i++)
        begin
            send_meeting(32'd0, start_t'($urandom) | 32'h8000_0000, i == MAX_ROOMS + 1);
        end
        wait_drained();

        // --- one room, maximal durations, no idling on either side:
        //     every meeting after the first is postponed ---
        idle_pct = 0;
        set_room_count(CFG_W'(1));
        for (int i = 0; i < 150; i++)
        begin
            send_meeting(32'd0, 32'hFFFF_FFFF, i == 149);
        end
        wait_drained();
        idle_pct = 17;

        // --- random batches, mostly well-formed with a sprinkling of noise ---
        sent       = 0;
        batch_open = 1'b0;
        cursor     = '0;
        while (sent < 1200)
        begin
            // small room counts most of the time: a full scan is slow
            sel = $urandom_range(99);
            if (sel < 6)
            begin
                rc = CFG_W'(MAX_ROOMS);
            end
            else if (sel < 9)
            begin
                rc = CFG_W'($urandom_range(129, 255));
            end
            else if (sel < 11)
            begin
                rc = '0;
            end
            else
            begin
                rc = CFG_W'($urandom_range(1, 12));
            end
            set_room_count(rc);

            len     = (rc > CFG_W'(12)) ? $urandom_range(2, 30) : $urandom_range(1, 40);
            sel     = $urandom_range(2);
            gap_max = (sel == 0) ? 0 : ((sel == 1) ? 3 : 50);
            sel     = $urandom_range(2);
            dur_max = (sel == 0) ? 4 : ((sel == 1) ? 40 : 1000);
            if (!batch_open)
            begin
                cursor = ($urandom_range(7) == 0) ?
                         start_t'($urandom_range(32'hF000_0000, 32'hFFFF_FFFF)) :
                         start_t'($urandom_range(1000));
            end
            batch_open = 1'b1;

            for (int i = 0; i < len; i++)
            begin
                // a batch sometimes runs on across a room count change
                last = (i == len - 1) && ($urandom_range(3) != 0);
                if ($urandom_range(9) == 0)
                begin
                    s = start_t'($urandom);
                    e = start_t'($urandom);
                end
                else
                begin
                    acc    = {1'b0, cursor} + 33'($urandom_range(0, gap_max));
                    cursor = acc[32] ? '1 : acc[31:0];
                    s      = cursor;
                    acc    = {1'b0, s} + 33'($urandom_range(1, dur_max));
                    e      = acc[32] ? '1 : acc[31:0];
                end
                send_meeting(s, e, last);
                sent++;
                if (last)
                begin
                    batch_open = 1'b0;
                end
            end
            wait_drained();
        end

        // close any open batch
        if (batch_open)
        begin
            send_meeting(cursor, cursor, 1'b1);
        end

        wait_drained();
        repeat (150) @(posedge clk);
        if (mismatch_count == 0 && open_bookings == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
